// ===== rtl/core/wpm_pkg.sv =====
// Shared types and constants for the wildcard pattern matcher.
// No dependencies; used by wpm_cell and wildcard_pattern_matcher_top.
package wpm_pkg;

  localparam int unsigned CHAR_W          = 16;
  localparam int unsigned MAX_PATTERN_DEF = 64;

  localparam logic [CHAR_W-1:0] CH_ANY_ONE = 16'h003F;  // '?'
  localparam logic [CHAR_W-1:0] CH_ANY_RUN = 16'h002A;  // '*'

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_TEXT    = 2'd3
  } cmd_e;

  // Token handed from one cell to the next during a row sweep.
  typedef struct packed {
    logic vld;
    logic prev;  // row bit of the sender before this sweep
    logic cur;   // row bit of the sender after this sweep
  } link_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic wr_en;  // store the broadcast pattern character
    logic last;   // cell holds the final pattern character
  } cell_ctl_t;

  // Signals broadcast to every cell.
  typedef struct packed {
    logic              text_mode;  // 1: advance on text char, 0: rebuild empty-text row
    logic [CHAR_W-1:0] text_char;
    logic [CHAR_W-1:0] wr_char;
  } bcast_t;

endpackage

// ===== rtl/core/wildcard_pattern_matcher_top.sv =====
// Glob-style wildcard matcher: '?' matches one character, '*' any run. Each request
// returns one result. Pattern characters are held in a row of MAX_PATTERN cells; a
// text character, a restart or an append sends a token down the row, one cell per
// cycle, and the result is loaded into the output register after the token reaches
// the last pattern cell. A clear, or a restart or text character with an empty
// pattern, sends no token. A new request is taken once
// the previous one has its result in the output register, even while that result
// waits to be taken.
// Depends on wpm_pkg and wpm_cell.
module wildcard_pattern_matcher_top
  import wpm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // [1:0] cmd, [17:2] char_code, [23:18] zero
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o    // [0] matched, [1] overflow, [7:2] zero
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic              row0_q, row0_d;
  logic              text_q, text_d;
  logic [CHAR_W-1:0] char_q, char_d;
  link_t             launch_q, launch_d;
  logic              m_tvalid_q, m_tvalid_d;
  logic [7:0]        m_tdata_q, m_tdata_d;

  cmd_e              in_cmd;
  logic [CHAR_W-1:0] in_char;
  logic              accept;
  logic              full;
  logic [LEN_W-1:0]  len_m1;
  logic              matched;
  logic              done;

  bcast_t                  bcast;
  cell_ctl_t [MAX_PATTERN-1:0] cell_ctl;
  link_t     [MAX_PATTERN-1:0] cell_link;
  logic      [MAX_PATTERN-1:0] row_bits;
  logic      [MAX_PATTERN-1:0] cell_fin;
  logic      [MAX_PATTERN-1:0] tok_vld;

  assign in_cmd  = cmd_e'(s_tdata_i[1:0]);
  assign in_char = s_tdata_i[17:2];
  assign accept  = s_tvalid_i & s_tready_o;
  assign full    = (len_q == LEN_MAX);
  assign len_m1  = len_q - LEN_W'(1);
  assign matched = (len_q == '0) ? row0_q : row_bits[len_m1[IDX_W-1:0]];
  assign done    = |cell_fin;

  assign bcast = '{text_mode: text_q, text_char: char_q, wr_char: in_char};

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    assign cell_ctl[i].wr_en = accept && (in_cmd == CMD_APPEND) && !full
                               && (len_q == LEN_W'(i));
    assign cell_ctl[i].last  = (len_q == LEN_W'(i + 1));
    assign tok_vld[i]        = cell_link[i].vld;

    wpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bcast_i (bcast),
      .ctl_i   (cell_ctl[i]),
      .link_i  ((i == 0) ? launch_q : cell_link[(i == 0) ? 0 : i - 1]),
      .link_o  (cell_link[i]),
      .row_o   (row_bits[i]),
      .fin_o   (cell_fin[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    row0_d     = row0_q;
    text_d     = text_q;
    char_d     = char_q;
    launch_d   = '{vld: 1'b0, prev: 1'b0, cur: 1'b0};
    m_tvalid_d = m_tvalid_q & ~m_tready_i;
    m_tdata_d  = m_tdata_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_FIN;
          case (in_cmd)
            CMD_CLEAR: begin
              len_d  = '0;
              ovf_d  = 1'b0;
              row0_d = 1'b1;
            end
            CMD_APPEND: begin
              row0_d = 1'b1;
              text_d = 1'b0;
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                len_d = len_q + LEN_W'(1);
              end
              launch_d = '{vld: 1'b1, prev: 1'b0, cur: 1'b1};
              state_d  = ST_RUN;
            end
            CMD_RESTART: begin
              row0_d = 1'b1;
              text_d = 1'b0;
              if (len_q != '0) begin
                launch_d = '{vld: 1'b1, prev: 1'b0, cur: 1'b1};
                state_d  = ST_RUN;
              end
            end
            CMD_TEXT: begin
              row0_d = 1'b0;
              text_d = 1'b1;
              char_d = in_char;
              if (len_q != '0) begin
                launch_d = '{vld: 1'b1, prev: row0_q, cur: 1'b0};
                state_d  = ST_RUN;
              end
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_tvalid_q || m_tready_i) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {6'b0, ovf_q, matched};
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      row0_q     <= 1'b1;
      text_q     <= 1'b0;
      char_q     <= '0;
      launch_q   <= '{vld: 1'b0, prev: 1'b0, cur: 1'b0};
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      row0_q     <= row0_d;
      text_q     <= text_d;
      char_q     <= char_d;
      launch_q   <= launch_d;
      m_tvalid_q <= m_tvalid_d;
      m_tdata_q  <= m_tdata_d;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

`ifndef SYNTHESIS
  // A single token walks the chain, so at most one cell can finish.
  a_one_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_fin))
    else $error("more than one cell finished in a cycle");

  // No token is left in the chain once the block takes requests again.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!launch_q.vld && tok_vld == '0))
    else $error("token still in chain while idle");

  // Overflow can only be set with a full store.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == LEN_MAX))
    else $error("overflow flag without full pattern store");

  // The sweep ends only while running.
  a_fin_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (state_q == ST_RUN))
    else $error("cell finished outside a sweep");
`endif

endmodule

// ===== rtl/core/wpm_cell.sv =====
// One matcher cell: holds one pattern character and its row bit.
// Depends on wpm_pkg.
module wpm_cell
  import wpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bcast_t    bcast_i,
  input  cell_ctl_t ctl_i,
  input  link_t     link_i,
  output link_t     link_o,
  output logic      row_o,
  output logic      fin_o
);

  logic [CHAR_W-1:0] pchar_q;
  logic              row_q;
  logic              row_eff;
  logic              row_d;
  logic              link_vld_q;
  logic              link_prev_q;
  logic              link_cur_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      pchar_q <= bcast_i.wr_char;
    end
  end

  // Rebuild sweep treats the old row as all zero.
  assign row_eff = bcast_i.text_mode & row_q;

  always_comb begin
    if (pchar_q == CH_ANY_RUN) begin
      row_d = row_eff | link_i.cur;
    end else if (pchar_q == CH_ANY_ONE || pchar_q == bcast_i.text_char) begin
      row_d = link_i.prev;
    end else begin
      row_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= 1'b0;
      link_vld_q <= 1'b0;
    end else begin
      link_vld_q <= link_i.vld & ~ctl_i.last;
      if (link_i.vld) begin
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_i.vld) begin
      link_prev_q <= row_eff;
      link_cur_q  <= row_d;
    end
  end

  assign link_o = '{vld: link_vld_q, prev: link_prev_q, cur: link_cur_q};
  assign row_o  = row_q;
  assign fin_o  = link_i.vld & ctl_i.last;

endmodule

// ===== sim/wildcard_pattern_matcher_top_test.sv =====
// Stream testbench for wildcard_pattern_matcher_top: a directed table, then random
// pattern/text sequences, each result checked against typed-in expectations or a behavioral glob predictor.
// Depends on wpm_pkg and the RTL of wildcard_pattern_matcher_top.
`timescale 1ns / 1ps

module wildcard_pattern_matcher_top_test;
  import wpm_pkg::*;

  localparam int unsigned PAT_DEPTH = MAX_PATTERN_DEF;
  localparam int          N_DIR     = 24;
  localparam int          N_RAND    = 1400;
  localparam int          HOLD_CYC  = 400;
  localparam logic [CHAR_W-1:0] CH_A = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_B = 16'h0062;

  typedef struct packed {
    logic ovf;
    logic matched;
  } match_res_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [CHAR_W-1:0] ch;
    logic              fixed;      // expected result typed in below
    logic              exp_ovf;
    logic              exp_match;
  } dir_row_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [23:0] s_tdata_i  = '0;   // [1:0] cmd, [17:2] char_code, [23:18] zero
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [7:0]  m_tdata_o;         // [0] matched, [1] overflow, [7:2] zero

  // predictor state
  logic [CHAR_W-1:0] pat_mem [PAT_DEPTH];
  int unsigned       pat_len  = 0;
  logic [PAT_DEPTH:0] dp_row  = 1;
  logic              ovf_flag = 1'b0;

  match_res_t match_q [$];
  match_res_t got_res;
  match_res_t want_res;
  dir_row_t   dir_tbl [N_DIR];
  int         err_cnt   = 0;
  int         sent_cnt  = 0;
  int         run_phase = 0;
  int         hold_cnt  = 0;
  bit         held      = 1'b0;

  wildcard_pattern_matcher_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Row for empty text: bit 0, plus every prefix made only of stars.
  function automatic logic [PAT_DEPTH:0] empty_row();
    logic [PAT_DEPTH:0] r;
    logic run;
    r = 1;
    run = 1'b1;
    for (int j = 1; j <= pat_len; j++) begin
      run = run && (pat_mem[j-1] == CH_ANY_RUN);
      r[j] = run;
    end
    return r;
  endfunction

  function automatic match_res_t glob_step(cmd_e c, logic [CHAR_W-1:0] ch);
    logic [PAT_DEPTH:0] nxt;
    logic [CHAR_W-1:0]  pc;
    case (c)
      CMD_CLEAR: begin
        pat_len  = 0;
        ovf_flag = 1'b0;
        dp_row   = empty_row();
      end
      CMD_APPEND: begin
        if (pat_len < PAT_DEPTH) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          ovf_flag = 1'b1;
        end
        dp_row = empty_row();
      end
      CMD_RESTART: dp_row = empty_row();
      default: begin
        nxt = '0;
        for (int j = 1; j <= pat_len; j++) begin
          pc = pat_mem[j-1];
          // star rule wins even when the text char is a star too
          if (pc == CH_ANY_RUN) nxt[j] = dp_row[j] | nxt[j-1];
          else if (pc == CH_ANY_ONE || pc == ch) nxt[j] = dp_row[j-1];
          else nxt[j] = 1'b0;
        end
        dp_row = nxt;
      end
    endcase
    return '{ovf: ovf_flag, matched: dp_row[pat_len]};
  endfunction

  function automatic logic [CHAR_W-1:0] glob_char(int star_pct, int any_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < star_pct) return CH_ANY_RUN;
    if (r < star_pct + any_pct) return CH_ANY_ONE;
    if (r < 90) return ($urandom_range(0, 1) != 0) ? CH_A : CH_B;
    return CHAR_W'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic push_req(cmd_e c, logic [CHAR_W-1:0] ch, logic fixed, match_res_t fixed_res);
    match_res_t res;
    while ($urandom_range(0, 99) < ((run_phase == 0) ? 28 : (run_phase == 1) ? 87 : 0)) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {6'b0, ch, c};
    do @(posedge clk_i); while (!s_tready_o);
    res = glob_step(c, ch);
    match_q.push_back(fixed ? fixed_res : res);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // receiver ready: idle pattern per phase, one long hold-off in the last phase
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      m_tready_i <= 1'b0;
    end else if (run_phase == 2 && !held) begin
      held       <= 1'b1;
      hold_cnt   <= HOLD_CYC;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= $urandom_range(0, 99) >= ((run_phase == 0) ? 87 :
                                              (run_phase == 1) ? 28 : 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got_res = '{ovf: m_tdata_o[1], matched: m_tdata_o[0]};
      if (match_q.size() == 0) begin
        if (err_cnt < 10) $display("unexpected result: tdata=%h", m_tdata_o);
        err_cnt++;
      end else begin
        want_res = match_q.pop_front();
        if (got_res.matched !== want_res.matched || got_res.ovf !== want_res.ovf ||
            m_tdata_o[7:2] !== 6'b0) begin
          if (err_cnt < 10)
            $display("mismatch at %0t: matched exp %b got %b, overflow exp %b got %b, pad %b",
                     $realtime, want_res.matched, got_res.matched, want_res.ovf,
                     got_res.ovf, m_tdata_o[7:2]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int r;
    int n;
    dir_tbl[0]  = '{CMD_TEXT,    16'hFFFF,   1'b1, 1'b0, 1'b0};  // empty pattern, text seen
    dir_tbl[1]  = '{CMD_RESTART, 16'h0000,   1'b1, 1'b0, 1'b1};
    dir_tbl[2]  = '{CMD_CLEAR,   16'hFFFF,   1'b1, 1'b0, 1'b1};
    dir_tbl[3]  = '{CMD_APPEND,  CH_ANY_RUN, 1'b1, 1'b0, 1'b1};  // lone star matches empty
    dir_tbl[4]  = '{CMD_TEXT,    16'h0000,   1'b1, 1'b0, 1'b1};
    dir_tbl[5]  = '{CMD_TEXT,    16'hFFFF,   1'b1, 1'b0, 1'b1};
    dir_tbl[6]  = '{CMD_APPEND,  CH_A,       1'b1, 1'b0, 1'b0};
    dir_tbl[7]  = '{CMD_TEXT,    CH_A,       1'b0, 1'b0, 1'b0};
    dir_tbl[8]  = '{CMD_TEXT,    CH_ANY_RUN, 1'b0, 1'b0, 1'b0};
    dir_tbl[9]  = '{CMD_TEXT,    CH_A,       1'b0, 1'b0, 1'b0};
    dir_tbl[10] = '{CMD_CLEAR,   16'h0000,   1'b1, 1'b0, 1'b1};
    dir_tbl[11] = '{CMD_APPEND,  CH_ANY_ONE, 1'b1, 1'b0, 1'b0};
    dir_tbl[12] = '{CMD_TEXT,    16'hFFFF,   1'b0, 1'b0, 1'b0};
    dir_tbl[13] = '{CMD_TEXT,    16'h0000,   1'b0, 1'b0, 1'b0};
    dir_tbl[14] = '{CMD_RESTART, 16'h5555,   1'b0, 1'b0, 1'b0};
    dir_tbl[15] = '{CMD_TEXT,    CH_ANY_ONE, 1'b0, 1'b0, 1'b0};
    dir_tbl[16] = '{CMD_APPEND,  CH_ANY_RUN, 1'b0, 1'b0, 1'b0};
    dir_tbl[17] = '{CMD_TEXT,    CH_ANY_RUN, 1'b0, 1'b0, 1'b0};  // star facing star
    dir_tbl[18] = '{CMD_TEXT,    CH_ANY_RUN, 1'b0, 1'b0, 1'b0};
    dir_tbl[19] = '{CMD_APPEND,  16'hFFFF,   1'b0, 1'b0, 1'b0};
    dir_tbl[20] = '{CMD_TEXT,    16'h1234,   1'b0, 1'b0, 1'b0};
    dir_tbl[21] = '{CMD_TEXT,    16'hFFFF,   1'b0, 1'b0, 1'b0};
    dir_tbl[22] = '{CMD_RESTART, 16'hFFFF,   1'b0, 1'b0, 1'b0};
    dir_tbl[23] = '{CMD_CLEAR,   16'hAAAA,   1'b1, 1'b0, 1'b1};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIR; i++)
      push_req(dir_tbl[i].cmd, dir_tbl[i].ch, dir_tbl[i].fixed,
               '{ovf: dir_tbl[i].exp_ovf, matched: dir_tbl[i].exp_match});

    for (int scen = 0; sent_cnt < N_DIR + N_RAND; scen++) begin
      run_phase = (sent_cnt - N_DIR) * 3 / N_RAND;
      if (scen % 16 == 3) begin
        // fill the store, sometimes past the end, then scan a long text
        push_req(CMD_CLEAR, CHAR_W'($urandom), 1'b0, '0);
        n = PAT_DEPTH + ((scen == 3) ? 4 : $urandom_range(0, 6));
        for (int k = 0; k < n; k++) push_req(CMD_APPEND, glob_char(60, 20), 1'b0, '0);
        n = $urandom_range(0, 72);
        for (int k = 0; k < n; k++) push_req(CMD_TEXT, glob_char(3, 3), 1'b0, '0);
        if ($urandom_range(0, 1) != 0) push_req(CMD_RESTART, CHAR_W'($urandom), 1'b0, '0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // noise: anything goes
          n = $urandom_range(1, 6);
          for (int k = 0; k < n; k++)
            push_req(cmd_e'($urandom_range(0, 3)), CHAR_W'($urandom), 1'b0, '0);
        end else begin
          if (pat_len > 10 || $urandom_range(0, 99) < 75)
            push_req(CMD_CLEAR, CHAR_W'($urandom), 1'b0, '0);
          n = $urandom_range(0, 6);
          for (int k = 0; k < n; k++) push_req(CMD_APPEND, glob_char(30, 20), 1'b0, '0);
          if ($urandom_range(0, 99) < 40) push_req(CMD_RESTART, CHAR_W'($urandom), 1'b0, '0);
          n = $urandom_range(0, 10);
          for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 4) push_req(CMD_RESTART, CHAR_W'($urandom), 1'b0, '0);
            else push_req(CMD_TEXT, glob_char(8, 8), 1'b0, '0);
          end
        end
      end
    end
    s_tvalid_i <= 1'b0;

    while (match_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (err_cnt == 0 && match_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog: reports failure if the run does not finish
  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
